@@ src/fnpc_pkg.sv @@
// Shared constants and types for the four-neighbour peak clamp.
`default_nettype none

package fnpc_pkg;

   localparam int ROW_BITS       = 10;
   localparam int COL_OUT_BITS   = 10;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int HEIGHT_LIMIT   = 1024;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] FRAME_SIZE_RESET = 11'd1024;

   // one pixel produces at most three result beats; queue holds four
   localparam int RSP_SLOTS = 3;
   localparam int RSP_DEPTH = 4;

   typedef logic [1:0] push_count_type;
   typedef logic [2:0] fill_count_type;

endpackage

`default_nettype wire

@@ src/fnpc_rsp_fifo.sv @@
// Result queue: takes up to three beats per cycle, hands out one beat per cycle while the reader is ready.
`default_nettype none

module fnpc_rsp_fifo import fnpc_pkg::*; #(
   parameter int DATA_BITS = 37
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire push_count_type       push_n,
   input  wire logic [DATA_BITS-1:0] push_data [RSP_SLOTS],
   input  wire logic                 pop_ready,
   output logic                      head_valid,
   output logic [DATA_BITS-1:0]      head_data,
   output fill_count_type            fill
);

   localparam int PTR_BITS = $clog2(RSP_DEPTH);

   logic [DATA_BITS-1:0] slot_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   fill_count_type       count_ff, count_in;
   logic                 pop;

   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];
   assign fill       = count_ff;
   assign pop        = head_valid && pop_ready;

   always_comb begin
      wr_ptr_in = PTR_BITS'(wr_ptr_ff + PTR_BITS'(push_n));
      rd_ptr_in = pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = fill_count_type'(count_ff + fill_count_type'(push_n)
                                   - fill_count_type'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_SLOTS; i++) begin
         if (i < int'(push_n)) begin
            slot_ff[PTR_BITS'(wr_ptr_ff + PTR_BITS'(i))] <= push_data[i];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fill_count_type'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PTR_BITS'(wr_ptr_ff - rd_ptr_ff) == PTR_BITS'(count_ff))
      else $error("queue pointers disagree with fill count");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && (push_n == '0) |=> count_ff == fill_count_type'($past(count_ff) - 1'b1))
      else $error("fill count did not drop on a lone pop");
`endif

endmodule

`default_nettype wire

@@ src/four_neighbour_peak_clamp_top.sv @@
// An accepted pixel is registered in the input stage and queued as results when it advances.
// Throughput: one pixel per cycle while the result queue has room; the last row yields up to
// three beats per pixel, so there the input is paced by the result port.
// Line buffer is a one-port-read memory of MAX_WIDTH entries, prefetched one column ahead.
// Reset: counters, pipeline and result queue cleared, frame size 1024 x 1024;
// the line buffer is not cleared (every entry read within a frame is written first).
`default_nettype none

module four_neighbour_peak_clamp_top import fnpc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [PIXEL_BITS-1:0]     req_pixel_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ROW_BITS-1:0]            rsp_out_row,
   output logic [COL_OUT_BITS-1:0]        rsp_out_column,
   output logic [PIXEL_BITS-1:0]          rsp_out_value,
   output logic                           rsp_frame_done,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RSP_BITS = ROW_BITS + COL_OUT_BITS + PIXEL_BITS + 1;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] orig;
      logic [PIXEL_BITS-1:0] upd;
   } line_entry_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pix;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
   } item_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]     row;
      logic [COL_OUT_BITS-1:0] col;
      logic [PIXEL_BITS-1:0]   value;
      logic                    done;
   } rsp_type;

   function automatic logic [COL_BITS-1:0] width_last(input logic [CSR_DATA_BITS-1:0] v);
      logic [COL_BITS-1:0] res;
      if (v == '0) res = '0;
      else if (32'(v) > MAX_WIDTH) res = COL_BITS'(MAX_WIDTH - 1);
      else res = COL_BITS'(32'(v) - 1);
      return res;
   endfunction

   function automatic logic [ROW_BITS-1:0] height_last(input logic [CSR_DATA_BITS-1:0] v);
      logic [ROW_BITS-1:0] res;
      if (v == '0) res = '0;
      else if (32'(v) > HEIGHT_LIMIT) res = ROW_BITS'(HEIGHT_LIMIT - 1);
      else res = ROW_BITS'(32'(v) - 1);
      return res;
   endfunction

   // min(own, max of present neighbours); own when no neighbour exists
   function automatic logic [PIXEL_BITS-1:0] settle(
      input logic [PIXEL_BITS-1:0] own,
      input logic hu, input logic [PIXEL_BITS-1:0] u,
      input logic hl, input logic [PIXEL_BITS-1:0] l,
      input logic hr, input logic [PIXEL_BITS-1:0] r,
      input logic hd, input logic [PIXEL_BITS-1:0] d);
      logic                  any;
      logic [PIXEL_BITS-1:0] best;
      any  = 1'b0;
      best = '0;
      if (hu) begin
         best = u;
         any  = 1'b1;
      end
      if (hl && (!any || l > best)) best = l;
      any = any || hl;
      if (hr && (!any || r > best)) best = r;
      any = any || hr;
      if (hd && (!any || d > best)) best = d;
      any = any || hd;
      return !any ? own : ((own < best) ? own : best);
   endfunction

   // configuration
   logic [COL_BITS-1:0] w_last_ff, w_last_in;
   logic [ROW_BITS-1:0] h_last_ff, h_last_in;

   // accept side
   logic [COL_BITS-1:0] acc_col_ff, acc_col_in;
   logic [ROW_BITS-1:0] acc_row_ff, acc_row_in;
   logic                accept;
   logic                acc_col_last;
   logic [COL_BITS-1:0] rd_addr;

   // input stage
   item_type s1_ff, s1_in;
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_adv;

   // line buffer and prefetch window
   line_entry_type line_mem [MAX_WIDTH];
   line_entry_type mem_rd_ff;
   line_entry_type cur_ff, cur_in;

   // previous items, for the left neighbours and narrow-frame bypass
   logic [PIXEL_BITS-1:0] pix_prev_ff, pix_prev_in;
   logic [PIXEL_BITS-1:0] left_ff, left_in;
   logic [PIXEL_BITS-1:0] pix_prev2_ff, pix_prev2_in;
   logic [PIXEL_BITS-1:0] upd_prev2_ff, upd_prev2_in;
   logic [PIXEL_BITS-1:0] v2_prev_ff, v2_prev_in;

   // clamp logic
   line_entry_type        above;
   logic [PIXEL_BITS-1:0] right_orig;
   logic                  has_above, has_up2, has_left, has_left2, has_right, last_row;
   logic                  e0, e1, e2;
   logic [PIXEL_BITS-1:0] v1, v2, v3;
   rsp_type               rsp0, rsp1, rsp2, head;

   // result queue
   logic [RSP_BITS-1:0] push_data [RSP_SLOTS];
   logic [RSP_BITS-1:0] head_data;
   push_count_type      push_want;
   push_count_type      push_n;
   fill_count_type      fifo_fill;

   assign req_ready    = !s1_valid_ff || s1_adv;
   assign accept       = req_valid && req_ready;
   assign acc_col_last = acc_col_ff == w_last_ff;
   assign rd_addr      = acc_col_last ? '0 : COL_BITS'(acc_col_ff + 1'b1);
   assign s1_adv       = s1_valid_ff
                         && (({1'b0, fifo_fill} + 4'(push_want)) <= 4'(RSP_DEPTH));
   assign push_n       = s1_adv ? push_want : '0;

   always_comb begin
      w_last_in  = w_last_ff;
      h_last_in  = h_last_ff;
      acc_col_in = acc_col_ff;
      acc_row_in = acc_row_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in = width_last(csr_wdata);
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in = height_last(csr_wdata);
            end
            default: begin
            end
         endcase
         acc_col_in = '0;
         acc_row_in = '0;
      end else if (accept) begin
         if (acc_col_last) begin
            acc_col_in = '0;
            acc_row_in = (acc_row_ff == h_last_ff) ? '0 : ROW_BITS'(acc_row_ff + 1'b1);
         end else begin
            acc_col_in = COL_BITS'(acc_col_ff + 1'b1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      s1_in  = accept ? item_type'{pix: req_pixel_value, row: acc_row_ff, col: acc_col_ff}
                      : s1_ff;
      cur_in = accept ? mem_rd_ff : cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= width_last(FRAME_SIZE_RESET);
         h_last_ff   <= height_last(FRAME_SIZE_RESET);
         acc_col_ff  <= '0;
         acc_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
      end else begin
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         acc_col_ff  <= acc_col_in;
         acc_row_ff  <= acc_row_in;
         s1_valid_ff <= s1_valid_in;
         left_ff     <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      cur_ff       <= cur_in;
      pix_prev_ff  <= pix_prev_in;
      pix_prev2_ff <= pix_prev2_in;
      upd_prev2_ff <= upd_prev2_in;
      v2_prev_ff   <= v2_prev_in;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) line_mem[s1_ff.col] <= '{orig: s1_ff.pix, upd: v1};
      if (accept) mem_rd_ff <= line_mem[rd_addr];
   end

   always_comb begin
      has_above = s1_ff.row != '0;
      has_up2   = s1_ff.row > ROW_BITS'(1);
      has_left  = s1_ff.col != '0;
      has_left2 = s1_ff.col > COL_BITS'(1);
      has_right = s1_ff.col != w_last_ff;
      last_row  = s1_ff.row == h_last_ff;

      // frames one or two wide reach back into items still in flight
      if (w_last_ff == '0) above = '{orig: pix_prev_ff, upd: left_ff};
      else if (w_last_ff == COL_BITS'(1)) above = '{orig: pix_prev2_ff, upd: upd_prev2_ff};
      else above = cur_ff;
      right_orig = (w_last_ff == COL_BITS'(1)) ? pix_prev_ff : mem_rd_ff.orig;

      v1 = settle(above.orig, has_up2, above.upd, has_left, left_ff,
                  has_right, right_orig, 1'b1, s1_ff.pix);
      v2 = settle(pix_prev_ff, has_above, left_ff, has_left2, v2_prev_ff,
                  1'b1, s1_ff.pix, 1'b0, '0);
      v3 = settle(s1_ff.pix, has_above, v1, has_left, v2, 1'b0, '0, 1'b0, '0);

      e0 = has_above;
      e1 = last_row && has_left;
      e2 = last_row && !has_right;

      rsp0 = '{row: ROW_BITS'(s1_ff.row - 1'b1), col: COL_OUT_BITS'(s1_ff.col),
               value: v1, done: 1'b0};
      rsp1 = '{row: s1_ff.row, col: COL_OUT_BITS'(s1_ff.col - 1'b1),
               value: v2, done: 1'b0};
      rsp2 = '{row: s1_ff.row, col: COL_OUT_BITS'(s1_ff.col), value: v3, done: 1'b1};

      push_data[0] = e0 ? rsp0 : (e1 ? rsp1 : rsp2);
      push_data[1] = (e0 && e1) ? rsp1 : rsp2;
      push_data[2] = rsp2;
      push_want = push_count_type'(2'(e0) + 2'(e1) + 2'(e2));
   end

   always_comb begin
      pix_prev_in  = s1_adv ? s1_ff.pix    : pix_prev_ff;
      left_in      = s1_adv ? v1           : left_ff;
      pix_prev2_in = s1_adv ? pix_prev_ff  : pix_prev2_ff;
      upd_prev2_in = s1_adv ? left_ff      : upd_prev2_ff;
      v2_prev_in   = s1_adv ? v2           : v2_prev_ff;
   end

   fnpc_rsp_fifo #(
      .DATA_BITS (RSP_BITS)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push_data  (push_data),
      .pop_ready  (rsp_ready),
      .head_valid (rsp_valid),
      .head_data  (head_data),
      .fill       (fifo_fill)
   );

   assign head           = head_data;
   assign rsp_out_row    = head.row;
   assign rsp_out_column = head.col;
   assign rsp_out_value  = head.value;
   assign rsp_frame_done = head.done;

`ifndef NO_ASSERTIONS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat did not reach the input stage");

   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_ready)
      else $error("new beat taken while the input stage is stalled");

   a_last_row_pair: assert property (@(posedge clock) disable iff (reset)
      s1_adv && last_row && has_above && has_left |-> push_n >= 2'd2)
      else $error("last-row pixel pushed fewer than two results");
`endif

endmodule

`default_nettype wire
